// ----- src/swam_pkg.sv -----
`default_nettype none

package swam_pkg;

    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_UNKNOWN = 2'd1;
    localparam logic [1:0] STATUS_FULL    = 2'd2;

    localparam logic ACTION_REGISTER = 1'b0;
    localparam logic ACTION_READING  = 1'b1;

    localparam logic CFG_MAX_TEMP = 1'b0;
    localparam logic CFG_MIN_TEMP = 1'b1;

    localparam logic signed [15:0] MAX_TEMP_RESET = 16'sd7680;
    localparam logic signed [15:0] MIN_TEMP_RESET = 16'sd2560;

    localparam logic [63:0] FNV_PRODUCT = 64'd2166136261 * 64'd16777619;
    localparam logic [31:0] HOME_HASH   = FNV_PRODUCT[31:0];

    typedef struct packed {
        logic clr_write;
        logic load_in;
        logic hash_step;
        logic probe_next;
        logic write_reg;
        logic write_read;
        logic set_fail;
        logic acc_step;
        logic div_start;
        logic div_step;
        logic out_load;
    } swam_cmd_t;

    typedef struct packed {
        logic clr_last;
        logic hash_done;
        logic action;
        logic slot_free;
        logic key_match;
        logic probe_last;
        logic acc_done;
        logic div_done;
        logic out_free;
    } swam_sts_t;

endpackage

`default_nettype wire

// ----- src/sensor_window_average_monitor.sv -----
// A request is accepted and hashed to a home slot; then slots are probed one by
// one (a read, then a check) until a free slot or a matching key is found or
// every slot has been probed. A known reading then sums the stored readings and
// divides by their count, and last the output is loaded. A new request is taken
// only once the previous result is loaded, even while it waits at the output.
// After reset the block clears every slot of the table before it accepts a
// request; thresholds return to their reset values at once.
`default_nettype none

module sensor_window_average_monitor #(
    parameter int TABLE_SLOTS = 32,
    parameter int WINDOW_LEN  = 5
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic               s_action,
    input  wire logic [15:0]        s_sensor_id,
    input  wire logic [15:0]        s_room_number,
    input  wire logic signed [15:0] s_reading_value,
    input  wire logic [31:0]        s_reading_time,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic [1:0]              m_status,
    output logic [15:0]             m_echoed_id,
    output logic [15:0]             m_room_of_sensor,
    output logic signed [15:0]      m_window_average,
    output logic                    m_too_hot,
    output logic                    m_too_cold,
    output logic [31:0]             m_newest_time,
    output logic [5:0]              m_known_sensors,
    input  wire logic               cfg_we,
    input  wire logic               cfg_index,
    input  wire logic [15:0]        cfg_wdata
);
    import swam_pkg::*;

    swam_cmd_t cmd;
    swam_sts_t sts;

    swam_controller u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .cmd     (cmd),
        .sts     (sts)
    );

    swam_datapath #(
        .TABLE_SLOTS (TABLE_SLOTS),
        .WINDOW_LEN  (WINDOW_LEN)
    ) u_dp (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (cmd),
        .sts              (sts),
        .s_action         (s_action),
        .s_sensor_id      (s_sensor_id),
        .s_room_number    (s_room_number),
        .s_reading_value  (s_reading_value),
        .s_reading_time   (s_reading_time),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_wdata        (cfg_wdata),
        .m_ready          (m_ready),
        .m_valid          (m_valid),
        .m_status         (m_status),
        .m_echoed_id      (m_echoed_id),
        .m_room_of_sensor (m_room_of_sensor),
        .m_window_average (m_window_average),
        .m_too_hot        (m_too_hot),
        .m_too_cold       (m_too_cold),
        .m_newest_time    (m_newest_time),
        .m_known_sensors  (m_known_sensors)
    );

endmodule

`default_nettype wire

// ----- src/swam_datapath.sv -----
`default_nettype none

module swam_datapath #(
    parameter int TABLE_SLOTS = 32,
    parameter int WINDOW_LEN  = 5
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire swam_pkg::swam_cmd_t cmd,
    output swam_pkg::swam_sts_t      sts,
    input  wire logic                s_action,
    input  wire logic [15:0]         s_sensor_id,
    input  wire logic [15:0]         s_room_number,
    input  wire logic signed [15:0]  s_reading_value,
    input  wire logic [31:0]         s_reading_time,
    input  wire logic                cfg_we,
    input  wire logic                cfg_index,
    input  wire logic [15:0]         cfg_wdata,
    input  wire logic                m_ready,
    output logic                     m_valid,
    output logic [1:0]               m_status,
    output logic [15:0]              m_echoed_id,
    output logic [15:0]              m_room_of_sensor,
    output logic signed [15:0]       m_window_average,
    output logic                     m_too_hot,
    output logic                     m_too_cold,
    output logic [31:0]              m_newest_time,
    output logic [5:0]               m_known_sensors
);
    import swam_pkg::*;

    localparam int IDX_W   = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
    localparam int R_W     = $clog2(TABLE_SLOTS + 1) + 1;
    localparam int CNT_W   = $clog2(TABLE_SLOTS + 1);
    localparam int FILL_W  = $clog2(WINDOW_LEN + 1);
    localparam int REM_W   = FILL_W + 1;
    localparam int ROW_W   = WINDOW_LEN * 16;
    localparam int SUM_W   = 16 + FILL_W;
    localparam int DCNT_W  = $clog2(SUM_W);
    localparam int SLOT_W  = 33;
    localparam int SHIFT_W = 16 + $clog2(TABLE_SLOTS);
    localparam logic [63:0] RECIP_FULL =
        ((64'd1 << SHIFT_W) + 64'(TABLE_SLOTS) - 64'd1) / 64'(TABLE_SLOTS);
    localparam logic [16:0] RECIP = RECIP_FULL[16:0];
    localparam logic [63:0] HI_PART_FULL =
        {32'd0, HOME_HASH[31:16], 16'd0} % 64'(TABLE_SLOTS);
    localparam logic [R_W-1:0] HI_PART = R_W'(HI_PART_FULL);
    localparam logic [15:0] HASH_LO = HOME_HASH[15:0];

    logic                    action_reg;
    logic [15:0]             id_reg;
    logic [15:0]             room_in_reg;
    logic [15:0]             val_reg;
    logic [31:0]             time_reg;

    logic [15:0]             lo_reg;
    logic [3:0]              hcnt_reg;
    logic [32:0]             hprod_reg;
    logic [15:0]             hquot;
    logic [15:0]             hback;
    logic [R_W-1:0]          hrem_reg;
    logic [R_W-1:0]          hsum;
    logic [R_W-1:0]          hash_mod;

    logic [IDX_W-1:0]        idx_reg;
    logic [IDX_W-1:0]        idx_inc;
    logic [CNT_W-1:0]        pcnt_reg;

    logic [SLOT_W-1:0]       slot_mem [TABLE_SLOTS];
    logic [FILL_W-1:0]       fill_mem [TABLE_SLOTS];
    logic [ROW_W-1:0]        hist_mem [TABLE_SLOTS];
    logic [SLOT_W-1:0]       slot_rd;
    logic [FILL_W-1:0]       fill_rd;
    logic [ROW_W-1:0]        hist_rd;

    logic [ROW_W-1:0]        row_next;
    logic [FILL_W-1:0]       fill_next;
    logic [ROW_W-1:0]        row_reg;
    logic [FILL_W-1:0]       kcnt_reg;
    logic signed [SUM_W-1:0] sum_reg;

    logic [FILL_W-1:0]       div_reg;
    logic [SUM_W-1:0]        mag_reg;
    logic                    neg_reg;
    logic [REM_W-1:0]        drem_reg;
    logic [REM_W-1:0]        div_t;
    logic                    div_ge;
    logic [DCNT_W-1:0]       dcnt_reg;

    logic [1:0]              res_status_reg;
    logic [15:0]             res_room_reg;
    logic [31:0]             res_time_reg;
    logic                    res_avg_en_reg;
    logic [5:0]              used_count_reg;
    logic signed [15:0]      max_temp_reg;
    logic signed [15:0]      min_temp_reg;

    logic [15:0]             quot;
    logic signed [15:0]      avg;

    logic                    m_valid_reg;
    logic [1:0]              m_status_reg;
    logic [15:0]             m_echoed_id_reg;
    logic [15:0]             m_room_reg;
    logic signed [15:0]      m_avg_reg;
    logic                    m_hot_reg;
    logic                    m_cold_reg;
    logic [31:0]             m_time_reg;
    logic [5:0]              m_known_reg;

    assign hquot    = 16'(hprod_reg >> SHIFT_W);
    assign hback    = 16'(32'(hquot) * 32'(TABLE_SLOTS));
    assign hsum     = hrem_reg + HI_PART;
    assign hash_mod = (hsum >= R_W'(TABLE_SLOTS)) ? hsum - R_W'(TABLE_SLOTS) : hsum;
    assign idx_inc  = (idx_reg == IDX_W'(TABLE_SLOTS - 1)) ? '0 : idx_reg + 1'b1;

    assign row_next  = (hist_rd << 16) | ROW_W'(val_reg);
    assign fill_next = (fill_rd < FILL_W'(WINDOW_LEN)) ? fill_rd + 1'b1 : fill_rd;

    assign div_t  = {drem_reg[REM_W-2:0], mag_reg[SUM_W-1]};
    assign div_ge = div_t >= REM_W'(div_reg);

    assign quot = mag_reg[15:0];
    assign avg  = neg_reg ? -$signed(quot) : $signed(quot);

    always_comb begin
        sts.clr_last   = idx_reg == IDX_W'(TABLE_SLOTS - 1);
        sts.hash_done  = hcnt_reg == 4'd2;
        sts.action     = action_reg;
        sts.slot_free  = !slot_rd[32];
        sts.key_match  = slot_rd[31:16] == id_reg;
        sts.probe_last = pcnt_reg == CNT_W'(TABLE_SLOTS - 1);
        sts.acc_done   = kcnt_reg == FILL_W'(1);
        sts.div_done   = dcnt_reg == DCNT_W'(SUM_W - 1);
        sts.out_free   = !m_valid_reg || m_ready;
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            action_reg  <= s_action;
            id_reg      <= s_sensor_id;
            room_in_reg <= s_room_number;
            val_reg     <= s_reading_value;
            time_reg    <= s_reading_time;
            lo_reg      <= s_sensor_id ^ HASH_LO;
        end else if (cmd.hash_step) begin
            hprod_reg <= 33'(lo_reg) * 33'(RECIP);
            hrem_reg  <= R_W'(lo_reg - hback);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hcnt_reg <= '0;
            idx_reg  <= '0;
            pcnt_reg <= '0;
        end else begin
            if (cmd.load_in) begin
                hcnt_reg <= '0;
            end else if (cmd.hash_step) begin
                hcnt_reg <= hcnt_reg + 1'b1;
            end
            if (cmd.clr_write || cmd.probe_next) begin
                idx_reg <= idx_inc;
            end else if (cmd.hash_step && sts.hash_done) begin
                idx_reg <= hash_mod[IDX_W-1:0];
            end
            if (cmd.hash_step) begin
                pcnt_reg <= '0;
            end else if (cmd.probe_next) begin
                pcnt_reg <= pcnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.clr_write) begin
            slot_mem[idx_reg] <= '0;
        end else if (cmd.write_reg) begin
            slot_mem[idx_reg] <= {1'b1, id_reg, room_in_reg};
        end
        slot_rd <= slot_mem[idx_reg];
    end

    always_ff @(posedge aclk) begin
        if (cmd.write_reg) begin
            fill_mem[idx_reg] <= '0;
        end else if (cmd.write_read) begin
            fill_mem[idx_reg] <= fill_next;
        end
        fill_rd <= fill_mem[idx_reg];
    end

    always_ff @(posedge aclk) begin
        if (cmd.write_read) begin
            hist_mem[idx_reg] <= row_next;
        end
        hist_rd <= hist_mem[idx_reg];
    end

    always_ff @(posedge aclk) begin
        if (cmd.write_read) begin
            row_reg  <= row_next;
            kcnt_reg <= fill_next;
            div_reg  <= fill_next;
            sum_reg  <= '0;
        end else if (cmd.acc_step) begin
            row_reg  <= row_reg >> 16;
            kcnt_reg <= kcnt_reg - 1'b1;
            sum_reg  <= sum_reg + SUM_W'($signed(row_reg[15:0]));
        end
        if (cmd.div_start) begin
            neg_reg  <= sum_reg[SUM_W-1];
            mag_reg  <= sum_reg[SUM_W-1] ? SUM_W'(-sum_reg) : SUM_W'(sum_reg);
            drem_reg <= '0;
            dcnt_reg <= '0;
        end else if (cmd.div_step) begin
            drem_reg <= div_ge ? div_t - REM_W'(div_reg) : div_t;
            mag_reg  <= {mag_reg[SUM_W-2:0], div_ge};
            dcnt_reg <= dcnt_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            res_status_reg <= STATUS_OK;
            res_room_reg   <= '0;
            res_time_reg   <= '0;
            res_avg_en_reg <= 1'b0;
        end else if (cmd.set_fail) begin
            res_status_reg <= (action_reg == ACTION_READING) ? STATUS_UNKNOWN : STATUS_FULL;
        end else if (cmd.write_reg) begin
            res_room_reg <= room_in_reg;
        end else if (cmd.write_read) begin
            res_room_reg   <= slot_rd[15:0];
            res_time_reg   <= time_reg;
            res_avg_en_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            used_count_reg <= '0;
            max_temp_reg   <= MAX_TEMP_RESET;
            min_temp_reg   <= MIN_TEMP_RESET;
        end else begin
            if (cmd.write_reg && sts.slot_free) begin
                used_count_reg <= used_count_reg + 1'b1;
            end
            if (cfg_we) begin
                case (cfg_index)
                    CFG_MAX_TEMP: max_temp_reg <= cfg_wdata;
                    CFG_MIN_TEMP: min_temp_reg <= cfg_wdata;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_status_reg    <= res_status_reg;
            m_echoed_id_reg <= id_reg;
            m_room_reg      <= res_room_reg;
            m_avg_reg       <= res_avg_en_reg ? avg : 16'sd0;
            m_hot_reg       <= res_avg_en_reg && (avg > max_temp_reg);
            m_cold_reg      <= res_avg_en_reg && (avg < min_temp_reg);
            m_time_reg      <= res_time_reg;
            m_known_reg     <= used_count_reg;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_status         = m_status_reg;
    assign m_echoed_id      = m_echoed_id_reg;
    assign m_room_of_sensor = m_room_reg;
    assign m_window_average = m_avg_reg;
    assign m_too_hot        = m_hot_reg;
    assign m_too_cold       = m_cold_reg;
    assign m_newest_time    = m_time_reg;
    assign m_known_sensors  = m_known_reg;

endmodule

`default_nettype wire

// ----- src/swam_controller.sv -----
`default_nettype none

module swam_controller (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    output swam_pkg::swam_cmd_t      cmd,
    input  wire swam_pkg::swam_sts_t sts
);
    import swam_pkg::*;

    typedef enum logic [8:0] {
        ST_CLEAR = 9'b000000001,
        ST_IDLE  = 9'b000000010,
        ST_HASH  = 9'b000000100,
        ST_READ  = 9'b000001000,
        ST_CHECK = 9'b000010000,
        ST_ACC   = 9'b000100000,
        ST_DIVI  = 9'b001000000,
        ST_DIV   = 9'b010000000,
        ST_OUT   = 9'b100000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            ST_CLEAR: begin
                cmd.clr_write = 1'b1;
                if (sts.clr_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_HASH;
                end
            end
            ST_HASH: begin
                cmd.hash_step = 1'b1;
                if (sts.hash_done) begin
                    state_next = ST_READ;
                end
            end
            ST_READ: begin
                state_next = ST_CHECK;
            end
            ST_CHECK: begin
                if (sts.slot_free) begin
                    if (sts.action == ACTION_READING) begin
                        cmd.set_fail = 1'b1;
                    end else begin
                        cmd.write_reg = 1'b1;
                    end
                    state_next = ST_OUT;
                end else if (sts.key_match) begin
                    if (sts.action == ACTION_READING) begin
                        cmd.write_read = 1'b1;
                        state_next     = ST_ACC;
                    end else begin
                        cmd.write_reg = 1'b1;
                        state_next    = ST_OUT;
                    end
                end else if (sts.probe_last) begin
                    cmd.set_fail = 1'b1;
                    state_next   = ST_OUT;
                end else begin
                    cmd.probe_next = 1'b1;
                    state_next     = ST_READ;
                end
            end
            ST_ACC: begin
                cmd.acc_step = 1'b1;
                if (sts.acc_done) begin
                    state_next = ST_DIVI;
                end
            end
            ST_DIVI: begin
                cmd.div_start = 1'b1;
                state_next    = ST_DIV;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (sts.div_done) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire
